/* design/pid_motor_drive_with_deadband_top_assert.svh */
// ----------------------------------------------------------------------------
// PID motor drive assertion macros
// Clocked, reset-qualified assertion wrappers used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef PID_MOTOR_DRIVE_WITH_DEADBAND_TOP_ASSERT_SVH
`define PID_MOTOR_DRIVE_WITH_DEADBAND_TOP_ASSERT_SVH

// property holds at every edge outside reset
`define PMD_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pmd_pkg.sv */
// ----------------------------------------------------------------------------
// PID motor drive package
// Shared constants, register indexes, payload and state types.
// ----------------------------------------------------------------------------
package pmd_pkg;

    localparam int unsigned DUTY_BITS         = 13;
    localparam int unsigned FRACTION_BITS_DEF = 16;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 3;

    // serial radix-4 multiplier geometry
    localparam int unsigned OPND_W   = 33;
    localparam int unsigned DIGITS   = 17;
    localparam int unsigned MPLIER_W = 2 * DIGITS;
    localparam int unsigned ACC_W    = 36;
    localparam int unsigned PROD_W   = ACC_W + MPLIER_W;
    localparam int unsigned COUNT_W  = $clog2(DIGITS);

    localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_SPEED,
        CFG_TARGET_RECIP,
        CFG_PROP_GAIN,
        CFG_DERIV_GAIN,
        CFG_INTEG_GAIN,
        CFG_DEADBAND,
        CFG_TIMEOUT
    } t_cfg_idx;

    localparam logic [30:0]        RST_TARGET_SPEED = 31'd7209;
    localparam logic [30:0]        RST_TARGET_RECIP = 31'd595782;
    localparam logic signed [31:0] RST_PROP_GAIN    = 32'sd65536;
    localparam logic signed [31:0] RST_DERIV_GAIN   = 32'sd0;
    localparam logic signed [31:0] RST_INTEG_GAIN   = 32'sd0;
    localparam logic [30:0]        RST_DEADBAND     = 31'd66;
    localparam logic [31:0]        RST_TIMEOUT      = 32'd500;

    typedef struct packed {
        logic [30:0]        speed_setpoint;
        logic [30:0]        target_reciprocal;
        logic signed [31:0] proportional_gain;
        logic signed [31:0] derivative_gain_per_period;
        logic signed [31:0] integral_gain_times_period;
        logic [30:0]        position_deadband;
        logic [31:0]        cmd_timeout;
    } t_cfg;

    typedef enum logic [1:0] {
        DRV_DRIVING  = 2'd0,
        DRV_DEADBAND = 2'd1,
        DRV_TIMEOUT  = 2'd2
    } t_drive_status;

    typedef struct packed {
        logic [31:0]        now_ticks;
        logic [31:0]        last_update_ticks;
        logic signed [31:0] position_error;
        logic signed [31:0] measured_speed;
        logic               sensor_present;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty_forward;
        logic [DUTY_BITS-1:0] duty_reverse;
        t_drive_status        drive_status;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_PREP,
        ST_PROP,
        ST_DERIV,
        ST_INTEG,
        ST_CLAMP,
        ST_EMIT
    } t_state;

endpackage

/* design/pid_motor_drive_with_deadband_top.sv */
// The four serial multiplies (normalise, proportional, derivative, integral) run one
// after another on the single shared Booth multiplier; a timed-out item skips them.
// A new item is taken only once the sequencer is idle again after emitting the last one.
// Reset: synchronous, active low; the configuration registers return to their reset values
// and the PID state (previous error, integral) clears to zero.
// ----------------------------------------------------------------------------
// PID motor drive with deadband
// Speed PID with timeout stop, duty clamp and direction/deadband routing.
// ----------------------------------------------------------------------------
`include "pid_motor_drive_with_deadband_top_assert.svh"

module pid_motor_drive_with_deadband_top import pmd_pkg::*; #(
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int unsigned TERM_W = PROD_W - FRACTION_BITS;
    localparam int unsigned PID_W  = TERM_W + 2;
    localparam int unsigned MAG_W  = FRACTION_BITS + 1;
    localparam int unsigned DPROD_W = MAG_W + DUTY_BITS;

    localparam logic signed [PID_W-1:0] PID_ONE =
        {{(PID_W-1){1'b0}}, 1'b1} << FRACTION_BITS;
    localparam logic signed [PID_W-1:0] PID_NEG_ONE = -PID_ONE;
    localparam logic [MAG_W-1:0] MAG_ONE = {1'b1, {(MAG_W-1){1'b0}}};

    t_cfg                     w_cfg;
    t_state                   r_state;
    t_state                   n_state;

    logic                     w_in_accept;
    logic                     w_out_free;
    logic                     w_mul_start;
    logic signed [OPND_W-1:0] w_mul_a;
    logic signed [OPND_W-1:0] w_mul_b;
    logic                     w_mul_done;
    logic signed [PROD_W-1:0] w_product;

    logic [31:0]              w_elapsed;
    logic                     w_timed_out;
    logic signed [OPND_W-1:0] w_speed;
    logic signed [OPND_W-1:0] w_speed_err;

    logic signed [TERM_W-1:0] w_term;
    logic                     w_term_fits;
    logic signed [31:0]       w_norm_sat;
    logic signed [32:0]       w_diff_raw;
    logic signed [32:0]       w_integ_raw;
    logic signed [31:0]       w_diff_sat;
    logic signed [31:0]       w_integ_sat;

    logic signed [MAG_W:0]    w_pid_small;
    logic signed [MAG_W:0]    w_pid_abs;
    logic [MAG_W-1:0]         w_mag;
    logic signed [32:0]       w_perr_ext;
    logic [32:0]              w_aperr;
    logic [DPROD_W-1:0]       w_duty_prod;
    logic [DUTY_BITS-1:0]     w_duty;

    logic signed [31:0]       r_perr;
    logic                     r_timeout;
    logic signed [31:0]       r_norm;
    logic signed [31:0]       r_diff;
    logic signed [31:0]       r_integ_next;
    logic signed [31:0]       r_prev_norm;
    logic signed [31:0]       r_integ;
    logic signed [PID_W-1:0]  r_pid;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_in_band;
    logic                     r_out_valid;
    t_out_item                r_out_item;

    pmd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pmd_booth_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (w_mul_a),
        .i_mplier  (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_elapsed   = i_in_item.now_ticks - i_in_item.last_update_ticks;
    assign w_timed_out = (i_in_item.last_update_ticks == '0) ||
                         (w_elapsed > w_cfg.cmd_timeout);
    assign w_speed     = i_in_item.sensor_present ?
                         {i_in_item.measured_speed[31], i_in_item.measured_speed} : '0;
    assign w_speed_err = $signed({2'b00, w_cfg.speed_setpoint}) - w_speed;

    assign w_term      = w_product[PROD_W-1:FRACTION_BITS];
    assign w_term_fits = (&w_term[TERM_W-1:31]) || !(|w_term[TERM_W-1:31]);
    assign w_norm_sat  = w_term_fits ? w_term[31:0] :
                         (w_term[TERM_W-1] ? INT32_MIN : INT32_MAX);

    assign w_diff_raw  = {r_norm[31], r_norm} - {r_prev_norm[31], r_prev_norm};
    assign w_integ_raw = {r_integ[31], r_integ} + {r_norm[31], r_norm};
    assign w_diff_sat  = (w_diff_raw[32] == w_diff_raw[31]) ? w_diff_raw[31:0] :
                         (w_diff_raw[32] ? INT32_MIN : INT32_MAX);
    assign w_integ_sat = (w_integ_raw[32] == w_integ_raw[31]) ? w_integ_raw[31:0] :
                         (w_integ_raw[32] ? INT32_MIN : INT32_MAX);

    assign w_pid_small = r_pid[MAG_W:0];
    assign w_pid_abs   = w_pid_small[MAG_W] ? -w_pid_small : w_pid_small;
    assign w_mag       = ((r_pid > PID_ONE) || (r_pid < PID_NEG_ONE)) ?
                         MAG_ONE : w_pid_abs[MAG_W-1:0];

    assign w_perr_ext  = {r_perr[31], r_perr};
    assign w_aperr     = r_perr[31] ? -w_perr_ext : w_perr_ext;

    assign w_duty_prod = {r_mag, {DUTY_BITS{1'b0}}} - {{DUTY_BITS{1'b0}}, r_mag};
    assign w_duty      = w_duty_prod[FRACTION_BITS+DUTY_BITS-1:FRACTION_BITS];

    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_mul_a     = w_speed_err;
        w_mul_b     = {2'b00, w_cfg.target_reciprocal};
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    if (w_timed_out) begin
                        n_state = ST_EMIT;
                    end else begin
                        w_mul_start = 1'b1;
                        n_state     = ST_NORM;
                    end
                end
            end
            ST_NORM: begin
                if (w_mul_done) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                w_mul_start = 1'b1;
                w_mul_a     = {r_norm[31], r_norm};
                w_mul_b     = {w_cfg.proportional_gain[31], w_cfg.proportional_gain};
                n_state     = ST_PROP;
            end
            ST_PROP: begin
                w_mul_a = {r_diff[31], r_diff};
                w_mul_b = {w_cfg.derivative_gain_per_period[31],
                           w_cfg.derivative_gain_per_period};
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    n_state     = ST_DERIV;
                end
            end
            ST_DERIV: begin
                w_mul_a = {r_integ_next[31], r_integ_next};
                w_mul_b = {w_cfg.integral_gain_times_period[31],
                           w_cfg.integral_gain_times_period};
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    n_state     = ST_INTEG;
                end
            end
            ST_INTEG: begin
                if (w_mul_done) begin
                    n_state = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev_norm <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_CLAMP) begin
                r_prev_norm <= r_norm;
                r_integ     <= r_integ_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    r_perr    <= i_in_item.position_error;
                    r_timeout <= w_timed_out;
                    r_pid     <= '0;
                end
            end
            ST_NORM: begin
                if (w_mul_done) begin
                    r_norm <= w_norm_sat;
                end
            end
            ST_PREP: begin
                r_diff       <= w_diff_sat;
                r_integ_next <= w_integ_sat;
            end
            ST_PROP, ST_DERIV, ST_INTEG: begin
                if (w_mul_done) begin
                    r_pid <= r_pid + {{(PID_W-TERM_W){w_term[TERM_W-1]}}, w_term};
                end
            end
            ST_CLAMP: begin
                r_mag     <= w_mag;
                r_in_band <= (w_aperr <= {2'b00, w_cfg.position_deadband});
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    if (r_timeout) begin
                        r_out_item.duty_forward <= '0;
                        r_out_item.duty_reverse <= '0;
                        r_out_item.drive_status <= DRV_TIMEOUT;
                    end else if (r_in_band) begin
                        r_out_item.duty_forward <= '0;
                        r_out_item.duty_reverse <= '0;
                        r_out_item.drive_status <= DRV_DEADBAND;
                    end else begin
                        r_out_item.drive_status <= DRV_DRIVING;
                        if (r_perr[31]) begin
                            r_out_item.duty_forward <= '0;
                            r_out_item.duty_reverse <= w_duty;
                        end else begin
                            r_out_item.duty_forward <= w_duty;
                            r_out_item.duty_reverse <= '0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `PMD_ASSERT_HOLDS(a_one_channel, i_clk, i_rst_n, !(o_out_valid && (o_out_item.duty_forward != '0) && (o_out_item.duty_reverse != '0)), "both channels driven")
    `PMD_ASSERT_HOLDS(a_stop_is_quiet, i_clk, i_rst_n, !(o_out_valid && (o_out_item.drive_status != DRV_DRIVING) && ((o_out_item.duty_forward != '0) || (o_out_item.duty_reverse != '0))), "stopped item carries duty")
    `PMD_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_in_accept, r_state != ST_IDLE, "item accepted but sequencer idle")
    `PMD_ASSERT_HOLDS(a_mul_done_waited, i_clk, i_rst_n, w_mul_done |-> ((r_state == ST_NORM) || (r_state == ST_PROP) || (r_state == ST_DERIV) || (r_state == ST_INTEG)), "multiplier result not awaited")

endmodule

/* design/pmd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// PID motor drive configuration registers
// Write-only register file decoded from a plain index/data port.
// ----------------------------------------------------------------------------
module pmd_cfg_regs import pmd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_setpoint             <= RST_TARGET_SPEED;
            r_cfg.target_reciprocal          <= RST_TARGET_RECIP;
            r_cfg.proportional_gain          <= RST_PROP_GAIN;
            r_cfg.derivative_gain_per_period <= RST_DERIV_GAIN;
            r_cfg.integral_gain_times_period <= RST_INTEG_GAIN;
            r_cfg.position_deadband          <= RST_DEADBAND;
            r_cfg.cmd_timeout                <= RST_TIMEOUT;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_SPEED: r_cfg.speed_setpoint             <= i_cfg_data[30:0];
                CFG_TARGET_RECIP: r_cfg.target_reciprocal          <= i_cfg_data[30:0];
                CFG_PROP_GAIN:    r_cfg.proportional_gain          <= $signed(i_cfg_data);
                CFG_DERIV_GAIN:   r_cfg.derivative_gain_per_period <= $signed(i_cfg_data);
                CFG_INTEG_GAIN:   r_cfg.integral_gain_times_period <= $signed(i_cfg_data);
                CFG_DEADBAND:     r_cfg.position_deadband          <= i_cfg_data[30:0];
                CFG_TIMEOUT:      r_cfg.cmd_timeout                <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/pmd_booth_mul.sv */
// ----------------------------------------------------------------------------
// PID motor drive serial multiplier
// Signed radix-4 Booth multiplier, one multiplier digit per cycle.
// ----------------------------------------------------------------------------
module pmd_booth_mul import pmd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [OPND_W-1:0] i_mcand,
    input  logic signed [OPND_W-1:0] i_mplier,
    output logic                     o_done,
    output logic signed [PROD_W-1:0] o_product
);

    localparam logic [2:0] BD_ZERO_LO  = 3'b000;
    localparam logic [2:0] BD_PLUS_A   = 3'b001;
    localparam logic [2:0] BD_PLUS_B   = 3'b010;
    localparam logic [2:0] BD_PLUS_TWO = 3'b011;
    localparam logic [2:0] BD_MINUS_TWO = 3'b100;
    localparam logic [2:0] BD_MINUS_A  = 3'b101;
    localparam logic [2:0] BD_MINUS_B  = 3'b110;
    localparam logic [2:0] BD_ZERO_HI  = 3'b111;

    logic signed [OPND_W-1:0] r_mcand;
    logic [MPLIER_W-1:0]      r_mplier;
    logic                     r_prev;
    logic signed [ACC_W-1:0]  r_hi;
    logic [MPLIER_W-1:0]      r_lo;
    logic [COUNT_W-1:0]       r_count;
    logic                     r_busy;
    logic                     r_done;

    logic signed [ACC_W-1:0]  w_a1;
    logic signed [ACC_W-1:0]  w_a2;
    logic signed [ACC_W-1:0]  w_pp;
    logic signed [ACC_W-1:0]  w_sum;
    logic [2:0]               w_code;

    assign w_a1   = {{(ACC_W-OPND_W){r_mcand[OPND_W-1]}}, r_mcand};
    assign w_a2   = w_a1 <<< 1;
    assign w_code = {r_mplier[1], r_mplier[0], r_prev};

    always_comb begin
        case (w_code) inside
            BD_PLUS_A, BD_PLUS_B:   w_pp = w_a1;
            BD_PLUS_TWO:            w_pp = w_a2;
            BD_MINUS_TWO:           w_pp = -w_a2;
            BD_MINUS_A, BD_MINUS_B: w_pp = -w_a1;
            BD_ZERO_LO, BD_ZERO_HI: w_pp = '0;
            default:                w_pp = '0;
        endcase
    end

    assign w_sum = r_hi + w_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= COUNT_W'(DIGITS - 1);
            end else if (r_busy) begin
                r_count <= r_count - 1'b1;
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= i_mcand;
            r_mplier <= {i_mplier[OPND_W-1], i_mplier};
            r_prev   <= 1'b0;
            r_hi     <= '0;
            r_lo     <= '0;
        end else if (r_busy) begin
            r_prev   <= r_mplier[1];
            r_mplier <= {2'b00, r_mplier[MPLIER_W-1:2]};
            r_lo     <= {w_sum[1:0], r_lo[MPLIER_W-1:2]};
            r_hi     <= {{2{w_sum[ACC_W-1]}}, w_sum[ACC_W-1:2]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

/* dv/pid_motor_drive_with_deadband_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID motor drive with deadband testbench
// Sends control ticks through the valid/stall input, predicts every duty and
// status item with its own fixed-point PID model, and checks each output item
// in order. Covers timeouts, deadband edges, direction routing, saturation of
// the error, difference and integral, register extremes, random gain sets,
// random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module pid_motor_drive_with_deadband_top_test;
    import pmd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam int unsigned FB = FRACTION_BITS_DEF;
    localparam longint PID_ONE = longint'(1) << FB;
    localparam longint DUTY_MAX = (longint'(1) << DUTY_BITS) - 1;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
    } t_reg_write;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    t_in_item               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_item;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    t_cfg        ctrl_cfg;
    longint      prev_norm_err;
    longint      integ_acc;
    t_out_item   duty_expected_q[$];

    int unsigned errors = 0;
    int unsigned ticks_sent = 0;
    int unsigned results_seen = 0;
    int unsigned settings_used = 1;
    int unsigned n_timeout = 0;
    int unsigned n_deadband = 0;
    int unsigned n_driving = 0;
    int unsigned hold_off_req = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;

    pid_motor_drive_with_deadband_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Timed out at %0t with %0d items outstanding", $time, duty_expected_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void model_reset();
        ctrl_cfg = '{speed_setpoint: RST_TARGET_SPEED, target_reciprocal: RST_TARGET_RECIP,
                     proportional_gain: RST_PROP_GAIN, derivative_gain_per_period: RST_DERIV_GAIN,
                     integral_gain_times_period: RST_INTEG_GAIN, position_deadband: RST_DEADBAND,
                     cmd_timeout: RST_TIMEOUT};
        prev_norm_err = 0;
        integ_acc = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TARGET_SPEED: ctrl_cfg.speed_setpoint = data[30:0];
            CFG_TARGET_RECIP: ctrl_cfg.target_reciprocal = data[30:0];
            CFG_PROP_GAIN:    ctrl_cfg.proportional_gain = data;
            CFG_DERIV_GAIN:   ctrl_cfg.derivative_gain_per_period = data;
            CFG_INTEG_GAIN:   ctrl_cfg.integral_gain_times_period = data;
            CFG_DEADBAND:     ctrl_cfg.position_deadband = data[30:0];
            CFG_TIMEOUT:      ctrl_cfg.cmd_timeout = data;
            default: ;
        endcase
    endfunction

    function automatic longint clip32(input longint x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic t_out_item pid_tick(input t_in_item it);
        t_out_item   r;
        logic [31:0] age;
        longint      spd, norm, diff, pid, mag, duty, perr, aperr;
        r = '0;
        age = it.now_ticks - it.last_update_ticks;
        if (it.last_update_ticks == 32'd0 || age > ctrl_cfg.cmd_timeout) begin
            r.drive_status = DRV_TIMEOUT;
            return r;
        end
        spd = it.sensor_present ? longint'($signed(it.measured_speed)) : 0;
        norm = clip32(((longint'(ctrl_cfg.speed_setpoint) - spd)
                      * longint'(ctrl_cfg.target_reciprocal)) >>> FB);
        diff = clip32(norm - prev_norm_err);
        integ_acc = clip32(integ_acc + norm);
        pid = ((norm * longint'($signed(ctrl_cfg.proportional_gain))) >>> FB)
            + ((diff * longint'($signed(ctrl_cfg.derivative_gain_per_period))) >>> FB)
            + ((integ_acc * longint'($signed(ctrl_cfg.integral_gain_times_period))) >>> FB);
        prev_norm_err = norm;
        if (pid > PID_ONE) pid = PID_ONE;
        if (pid < -PID_ONE) pid = -PID_ONE;
        mag = (pid < 0) ? -pid : pid;
        duty = ((mag * DUTY_MAX) >>> FB) & DUTY_MAX;
        perr = longint'($signed(it.position_error));
        aperr = (perr < 0) ? -perr : perr;
        if (aperr <= longint'(ctrl_cfg.position_deadband)) begin
            r.drive_status = DRV_DEADBAND;
        end else if (perr > 0) begin
            r.duty_forward = duty[DUTY_BITS-1:0];
            r.drive_status = DRV_DRIVING;
        end else begin
            r.duty_reverse = duty[DUTY_BITS-1:0];
            r.drive_status = DRV_DRIVING;
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic t_in_item make_tick(input logic [31:0] now, input logic [31:0] last,
                                           input logic [31:0] perr, input logic [31:0] spd,
                                           input logic sensor);
        t_in_item it;
        it.now_ticks = now;
        it.last_update_ticks = last;
        it.position_error = perr;
        it.measured_speed = spd;
        it.sensor_present = sensor;
        return it;
    endfunction

    function automatic t_in_item random_tick(input bit tidy);
        t_in_item    it;
        logic [31:0] age;
        longint      span, spd, lim, db;
        it.now_ticks = $urandom;
        it.sensor_present = $urandom_range(0, 1);
        if (!tidy) begin
            it.last_update_ticks = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom);
            it.position_error = $urandom;
            it.measured_speed = $urandom;
            return it;
        end
        case ($urandom_range(0, 9))
            0: age = ctrl_cfg.cmd_timeout;
            1: age = ctrl_cfg.cmd_timeout + 32'd1;
            default: age = $urandom_range(0, ctrl_cfg.cmd_timeout);
        endcase
        it.last_update_ticks = it.now_ticks - age;
        span = longint'(ctrl_cfg.speed_setpoint) / 4 + 1;
        spd = longint'(ctrl_cfg.speed_setpoint) + longint'($urandom_range(0, 2 * span)) - span;
        it.measured_speed = spd[31:0];
        db = longint'(ctrl_cfg.position_deadband);
        case ($urandom_range(0, 7))
            0: it.position_error = 32'(db);
            1: it.position_error = 32'(-db);
            2: it.position_error = 32'(db + 1);
            3: it.position_error = 32'(-db - 1);
            4: it.position_error = $urandom;
            default: begin
                lim = db * 2 + 64;
                if (lim > (longint'(1) << 30)) lim = longint'(1) << 30;
                it.position_error = 32'(longint'($urandom_range(0, 2 * lim)) - lim);
            end
        endcase
        return it;
    endfunction

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_tick(input t_in_item it);
        t_out_item   want;
        int unsigned gap;
        gap = pick_gap(tx_quiet);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        want = pid_tick(it);
        duty_expected_q.push_back(want);
        ticks_sent++;
        case (want.drive_status)
            DRV_TIMEOUT:  n_timeout++;
            DRV_DEADBAND: n_deadband++;
            default:      n_driving++;
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (duty_expected_q.size() != 0);
    endtask

    task automatic write_regs(input t_reg_write wr[$]);
        foreach (wr[k]) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= wr[k].idx;
            cfg_data <= wr[k].data;
            apply_reg(wr[k].idx, wr[k].data);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    function automatic logic [31:0] random_gain();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return 32'(longint'($urandom_range(0, 1 << 18)) - (1 << 17));
        if (r < 8) return 32'(longint'($urandom_range(0, 1 << 13)) - (1 << 12));
        return $urandom;
    endfunction

    task automatic program_random_settings();
        t_reg_write  wr[$];
        logic [31:0] ts, recip, db, tmo;
        ts = ($urandom_range(0, 4) == 0) ? 32'($urandom) : 32'($urandom_range(1, 1 << 22));
        if (ts[30:0] != 31'd0 && $urandom_range(0, 4) != 0) begin
            recip = 32'((64'h1_0000_0000 / longint'(ts[30:0])) & 64'h7fff_ffff);
        end else begin
            recip = $urandom;
        end
        case ($urandom_range(0, 9))
            0, 1:    db = 32'd0;
            2:       db = $urandom;
            default: db = $urandom_range(0, 1 << 16);
        endcase
        case ($urandom_range(0, 9))
            0:       tmo = 32'hffff_ffff;
            1, 2:    tmo = $urandom;
            default: tmo = $urandom_range(1, 2000);
        endcase
        wr = '{'{CFG_TARGET_SPEED, ts}, '{CFG_TARGET_RECIP, recip},
               '{CFG_PROP_GAIN, random_gain()}, '{CFG_DERIV_GAIN, random_gain()},
               '{CFG_INTEG_GAIN, random_gain()}, '{CFG_DEADBAND, db}, '{CFG_TIMEOUT, tmo}};
        if ($urandom_range(0, 4) == 0) wr.push_back('{CFG_IDX_SPARE, 32'($urandom)});
        write_regs(wr);
    endtask

    task automatic test_reset_defaults();
        send_tick(make_tick(32'd1000, 32'd0, 32'd5000, 32'd7209, 1'b1));
        send_tick(make_tick(32'd1500, 32'd1000, 32'd5000, 32'd0, 1'b1));
        send_tick(make_tick(32'd1501, 32'd1000, 32'd5000, 32'd0, 1'b1));
        send_tick(make_tick(32'd10, 32'hffff_fff0, -32'sd5000, 32'd3000, 1'b1));
        send_tick(make_tick(32'd20, 32'd15, 32'd66, 32'd100, 1'b1));
        send_tick(make_tick(32'd21, 32'd15, -32'sd66, 32'd100, 1'b1));
        send_tick(make_tick(32'd22, 32'd15, 32'd67, 32'd9000, 1'b1));
        send_tick(make_tick(32'd23, 32'd15, -32'sd67, 32'd9000, 1'b1));
        send_tick(make_tick(32'd24, 32'd15, INT32_MIN, 32'h8000_0000, 1'b0));
        send_tick(make_tick(32'd25, 32'd15, INT32_MAX, INT32_MIN, 1'b1));
        send_tick(make_tick(32'd26, 32'd15, 32'd0, INT32_MAX, 1'b1));
        send_tick(make_tick(32'hffff_ffff, 32'hffff_ffff, 32'd800, INT32_MAX, 1'b1));
        drain();
    endtask

    task automatic test_register_extremes();
        write_regs('{'{CFG_TARGET_SPEED, 32'h7fff_ffff}, '{CFG_TARGET_RECIP, 32'hffff_ffff},
                     '{CFG_PROP_GAIN, INT32_MIN}, '{CFG_DERIV_GAIN, INT32_MAX},
                     '{CFG_INTEG_GAIN, INT32_MAX}, '{CFG_DEADBAND, 32'd0},
                     '{CFG_TIMEOUT, 32'hffff_ffff}, '{CFG_IDX_SPARE, 32'h1234_5678}});
        send_tick(make_tick(32'd5, 32'hffff_ffff, 32'd0, 32'd0, 1'b1));
        send_tick(make_tick(32'd0, 32'd1, 32'd1, 32'd0, 1'b1));
        send_tick(make_tick(32'd7, 32'd3, -32'sd1, 32'd0, 1'b1));
        send_tick(make_tick(32'd9, 32'd0, 32'd1, 32'd0, 1'b1));
        drain();
        write_regs('{'{CFG_TARGET_SPEED, 32'd0}, '{CFG_TARGET_RECIP, 32'h7fff_ffff},
                     '{CFG_PROP_GAIN, INT32_MAX}, '{CFG_DERIV_GAIN, INT32_MIN},
                     '{CFG_INTEG_GAIN, INT32_MIN}, '{CFG_DEADBAND, 32'h7fff_ffff},
                     '{CFG_TIMEOUT, 32'd1}});
        send_tick(make_tick(32'd101, 32'd100, INT32_MIN, INT32_MAX, 1'b1));
        send_tick(make_tick(32'd102, 32'd101, INT32_MAX, INT32_MAX, 1'b1));
        send_tick(make_tick(32'd103, 32'd101, 32'd1, INT32_MAX, 1'b1));
        drain();
        write_regs('{'{CFG_TARGET_RECIP, 32'd0}});
        send_tick(make_tick(32'd200, 32'd200, -32'sd9, INT32_MIN, 1'b1));
        drain();
    endtask

    // receiver held off while the sender keeps offering, so the block backs up
    task automatic test_stall_fill();
        program_random_settings();
        tx_quiet = 1'b1;
        hold_off_req = 400;
        repeat (12) send_tick(random_tick(1'b1));
        tx_quiet = 1'b0;
        drain();
    endtask

    task automatic test_random_settings();
        repeat (8) begin
            program_random_settings();
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            repeat (60) send_tick(random_tick($urandom_range(0, 3) != 0));
            drain();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial begin : stall_gen
        int unsigned left;
        left = 0;
        forever begin
            @(negedge clk);
            if (hold_off_req != 0) begin
                left = hold_off_req;
                hold_off_req = 0;
            end else if (left == 0) begin
                left = pick_gap(rx_quiet);
            end
            if (left != 0) begin
                out_stall <= 1'b1;
                left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : duty_check
        t_out_item want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                if (duty_expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item fwd=%0d rev=%0d status=%0d", $time,
                             out_item.duty_forward, out_item.duty_reverse,
                             out_item.drive_status);
                end else begin
                    want = duty_expected_q.pop_front();
                    results_seen++;
                    if (out_item.duty_forward !== want.duty_forward) begin
                        errors++;
                        $display("%0t: duty_forward expected %0d got %0d", $time,
                                 want.duty_forward, out_item.duty_forward);
                    end
                    if (out_item.duty_reverse !== want.duty_reverse) begin
                        errors++;
                        $display("%0t: duty_reverse expected %0d got %0d", $time,
                                 want.duty_reverse, out_item.duty_reverse);
                    end
                    if (out_item.drive_status !== want.drive_status) begin
                        errors++;
                        $display("%0t: drive_status expected %0d got %0d", $time,
                                 want.drive_status, out_item.drive_status);
                    end
                end
            end
        end
    end

    initial begin
        model_reset();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_stall_fill();
        test_random_settings();
        drain();
        repeat (100) @(posedge clk);
        $display("Ran %0d ticks over %0d register settings, %0d output items checked",
                 ticks_sent, settings_used, results_seen);
        $display("Outcomes: %0d driving, %0d deadband stops, %0d timeout stops",
                 n_driving, n_deadband, n_timeout);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
